/* rtl/core/qrm_pkg.sv */
// Package for the quaternion to rotation matrix block.
// Payload structs, fixed-point widths and pipeline sizes; no dependencies.
package qrm_pkg;

   // fixed-point format of the fields
   localparam int FRAC_BITS = 14;
   localparam int FIELD_W   = 16;
   localparam int LANES     = 9;

   // datapath widths
   localparam int PROD_W = 2 * FIELD_W;        // one signed product
   localparam int NORM_W = PROD_W + 1;         // sum of four squares
   localparam int NUM_W  = PROD_W + 2;         // signed numerator
   localparam int MAG_W  = NUM_W - 1;          // numerator magnitude
   localparam int DEN_W  = NORM_W + 1;         // divisor 2N
   localparam int QB     = FRAC_BITS + 1;      // quotient bits
   localparam int REM_W  = DEN_W + QB;         // partial remainder
   localparam int SVAL_W = FIELD_W + QB;       // signed result before trim

   localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [FIELD_W-1:0] qx;
      logic signed [FIELD_W-1:0] qy;
      logic signed [FIELD_W-1:0] qz;
      logic signed [FIELD_W-1:0] qw;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] c0r0;
      logic signed [FIELD_W-1:0] c0r1;
      logic signed [FIELD_W-1:0] c0r2;
      logic signed [FIELD_W-1:0] c1r0;
      logic signed [FIELD_W-1:0] c1r1;
      logic signed [FIELD_W-1:0] c1r2;
      logic signed [FIELD_W-1:0] c2r0;
      logic signed [FIELD_W-1:0] c2r1;
      logic signed [FIELD_W-1:0] c2r2;
   } rsp_type;

endpackage

/* rtl/core/quaternion_to_rotation_matrix.sv */
// Quaternion to 3x3 rotation matrix, fully pipelined.
// Depends on qrm_pkg for payload structs and widths.
//
// Usage:
//   req channel carries one quaternion (qx, qy, qz, qw), signed, scaled by
//   2^FRAC_BITS. rsp channel carries the nine matrix entries, column-major,
//   each rounded half away from zero and clamped to +/-1.0. A zero
//   quaternion yields the identity.
//   Pipeline: the input register loads at the transfer edge, then
//   products, sums, divider setup, one restoring-division stage per
//   quotient bit, output register.
//   Throughput: one quaternion per cycle while the receiver does not
//   stall; the nine lanes of the divider work side by side, one
//   quotient bit per stage.
//   Reset clears every valid bit; payload registers are not reset.
//   When the receiver stalls, the whole pipeline holds in place and
//   req_ready drops; nothing is lost or repeated.
module quaternion_to_rotation_matrix
   import qrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic en;

   // stage 1: input register
   req_type s1_ff;
   logic    s1_vld_ff;

   // stage 2: products
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic                     s2_vld_ff;

   // stage 3: norm and numerators
   logic        [NORM_W-1:0] n3_ff;
   logic signed [NUM_W-1:0]  num3_ff [LANES];
   logic                     s3_vld_ff;

   // divider pipeline, index 0 is the setup stage
   logic [REM_W-1:0] rem_ff  [QB+1][LANES];
   logic [REM_W-1:0] rem_in  [QB+1][LANES];
   logic [QB-1:0]    quo_ff  [QB+1][LANES];
   logic [QB-1:0]    quo_in  [QB+1][LANES];
   logic [LANES-1:0] neg_ff  [QB+1];
   logic [DEN_W-1:0] den_ff  [QB+1];
   logic             zero_ff [QB+1];
   logic             dvld_ff [QB+1];

   // output register
   rsp_type out_ff, out_in;
   logic    out_vld_ff;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) dvld_ff[k] <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         dvld_ff[0] <= s3_vld_ff;
         for (int k = 1; k <= QB; k++) dvld_ff[k] <= dvld_ff[k-1];
         out_vld_ff <= dvld_ff[QB];
      end
   end

   // front stages: input register, products, then sums
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= req_data;
         xx_ff <= s1_ff.qx * s1_ff.qx;
         yy_ff <= s1_ff.qy * s1_ff.qy;
         zz_ff <= s1_ff.qz * s1_ff.qz;
         ww_ff <= s1_ff.qw * s1_ff.qw;
         xy_ff <= s1_ff.qx * s1_ff.qy;
         xz_ff <= s1_ff.qx * s1_ff.qz;
         yz_ff <= s1_ff.qy * s1_ff.qz;
         wx_ff <= s1_ff.qw * s1_ff.qx;
         wy_ff <= s1_ff.qw * s1_ff.qy;
         wz_ff <= s1_ff.qw * s1_ff.qz;
         n3_ff <= NORM_W'($unsigned(xx_ff)) + NORM_W'($unsigned(yy_ff))
                + NORM_W'($unsigned(zz_ff)) + NORM_W'($unsigned(ww_ff));
         num3_ff[0] <= NUM_W'(xx_ff) + NUM_W'(ww_ff) - NUM_W'(yy_ff) - NUM_W'(zz_ff);
         num3_ff[1] <= (NUM_W'(xy_ff) - NUM_W'(wz_ff)) <<< 1;
         num3_ff[2] <= (NUM_W'(xz_ff) + NUM_W'(wy_ff)) <<< 1;
         num3_ff[3] <= (NUM_W'(xy_ff) + NUM_W'(wz_ff)) <<< 1;
         num3_ff[4] <= NUM_W'(yy_ff) + NUM_W'(ww_ff) - NUM_W'(xx_ff) - NUM_W'(zz_ff);
         num3_ff[5] <= (NUM_W'(yz_ff) - NUM_W'(wx_ff)) <<< 1;
         num3_ff[6] <= (NUM_W'(xz_ff) - NUM_W'(wy_ff)) <<< 1;
         num3_ff[7] <= (NUM_W'(yz_ff) + NUM_W'(wx_ff)) <<< 1;
         num3_ff[8] <= NUM_W'(zz_ff) + NUM_W'(ww_ff) - NUM_W'(xx_ff) - NUM_W'(yy_ff);
      end
   end

   // divider setup: dividend |num|*2^QB + N over divisor 2N rounds half up
   always_comb begin
      logic [MAG_W-1:0] mag;
      for (int l = 0; l < LANES; l++) begin
         mag = num3_ff[l][NUM_W-1] ? MAG_W'(-num3_ff[l]) : MAG_W'(num3_ff[l]);
         rem_in[0][l] = (REM_W'(mag) << QB) + REM_W'(n3_ff);
         quo_in[0][l] = '0;
      end
      // one quotient bit per stage
      for (int k = 0; k < QB; k++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[k+1][l] = rem_ff[k][l];
            quo_in[k+1][l] = quo_ff[k][l];
            if (rem_ff[k][l] >= (REM_W'(den_ff[k]) << (QB - 1 - k))) begin
               rem_in[k+1][l] = rem_ff[k][l] - (REM_W'(den_ff[k]) << (QB - 1 - k));
               quo_in[k+1][l][QB-1-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= DEN_W'(n3_ff) << 1;
         zero_ff[0] <= (n3_ff == '0);
         for (int l = 0; l < LANES; l++) neg_ff[0][l] <= num3_ff[l][NUM_W-1];
         for (int k = 1; k <= QB; k++) begin
            den_ff[k]  <= den_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
         end
         for (int k = 0; k <= QB; k++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               quo_ff[k][l] <= quo_in[k][l];
            end
         end
      end
   end

   // clamp, restore sign, zero quaternion gives identity
   always_comb begin
      logic [QB-1:0]            q;
      logic signed [SVAL_W-1:0] v;
      logic [FIELD_W-1:0]       f [LANES];
      for (int l = 0; l < LANES; l++) begin
         q = (quo_ff[QB][l] > ONE_Q) ? ONE_Q : quo_ff[QB][l];
         v = neg_ff[QB][l] ? -SVAL_W'(q) : SVAL_W'(q);
         if (zero_ff[QB]) begin
            v = (l == 0 || l == 4 || l == 8) ? SVAL_W'(ONE_Q) : '0;
         end
         f[l] = v[FIELD_W-1:0];
      end
      out_in.c0r0 = f[0];
      out_in.c0r1 = f[1];
      out_in.c0r2 = f[2];
      out_in.c1r0 = f[3];
      out_in.c1r1 = f[4];
      out_in.c1r2 = f[5];
      out_in.c2r0 = f[6];
      out_in.c2r1 = f[7];
      out_in.c2r2 = f[8];
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   // checks
   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   a_stall_freezes_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (dvld_ff[QB] == $past(dvld_ff[QB])))
      else $error("pipeline advanced during stall");

   a_quotient_bounded: assert property (@(posedge clock) disable iff (reset)
      (dvld_ff[QB] && !zero_ff[QB]) |-> (quo_ff[QB][0] <= ONE_Q))
      else $error("quotient exceeds one");

endmodule

/* bench/qrm_checker.sv */
// Checker for the quaternion to rotation matrix block: predicts each matrix
// from the accepted quaternion and compares it with the returned one.
// Depends on qrm_pkg for the payload structs.
`timescale 1ns / 100ps

module qrm_checker
   import qrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_matrices
);

   rsp_type matrix_queue[$];

   // exact ratio num/den scaled by 2^FRAC_BITS, round half away, clamp to 1.0
   function automatic logic [15:0] scaled_ratio(longint num, longint den);
      longint unsigned one;
      longint unsigned mag;
      longint unsigned q;
      one = 64'd1 << FRAC_BITS;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = ((mag << (FRAC_BITS + 1)) + den) / (longint'(den) << 1);
      if (q > one) q = one;
      if (num < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic rsp_type rotation_of(req_type q);
      longint x, y, z, w, n;
      rsp_type m;
      x = q.qx; y = q.qy; z = q.qz; w = q.qw;
      n = x*x + y*y + z*z + w*w;
      m = '0;
      if (n == 0) begin
         m.c0r0 = 16'(1 << FRAC_BITS);
         m.c1r1 = 16'(1 << FRAC_BITS);
         m.c2r2 = 16'(1 << FRAC_BITS);
      end else begin
         m.c0r0 = scaled_ratio(x*x + w*w - y*y - z*z, n);
         m.c0r1 = scaled_ratio(2 * (x*y - w*z), n);
         m.c0r2 = scaled_ratio(2 * (x*z + w*y), n);
         m.c1r0 = scaled_ratio(2 * (x*y + w*z), n);
         m.c1r1 = scaled_ratio(y*y + w*w - x*x - z*z, n);
         m.c1r2 = scaled_ratio(2 * (y*z - w*x), n);
         m.c2r0 = scaled_ratio(2 * (x*z - w*y), n);
         m.c2r1 = scaled_ratio(2 * (y*z + w*x), n);
         m.c2r2 = scaled_ratio(z*z + w*w - x*x - y*y, n);
      end
      return m;
   endfunction

   assign pending_matrices = matrix_queue.size();

   // predict on each req transfer, compare on each rsp transfer
   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            matrix_queue.push_back(rotation_of(req_data));
         if (rsp_valid && rsp_ready) begin
            if (matrix_queue.size() == 0) begin
               $display("%0t: unexpected matrix %h", $time, rsp_data);
               errs = errs + 1;
            end else begin
               want = matrix_queue.pop_front();
               for (int k = 0; k < LANES; k++) begin
                  if (want[16*k +: 16] !== rsp_data[16*k +: 16]) begin
                     $display("%0t: entry %0d (msb first) expected %h got %h", $time,
                              LANES - 1 - k, want[16*k +: 16], rsp_data[16*k +: 16]);
                     errs = errs + 1;
                  end
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

/* bench/tb_top.sv */
// Top of the quaternion to rotation matrix bench: clock, reset, stimulus
// and verdict. Depends on qrm_pkg, the block and qrm_checker.
`timescale 1ns / 100ps

module tb_top;
   import qrm_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_matrices;
   int      quats_sent;

   quaternion_to_rotation_matrix i_dut (.*);

   qrm_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // receiver stall pattern: runs of ready, runs of stall, some stall-free spells
   initial begin
      int run_len;
      rsp_ready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 30);
         repeat (run_len) @(posedge clock) rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            run_len = $urandom_range(1, 8);
            repeat (run_len) @(posedge clock) rsp_ready <= 1'b0;
         end
      end
   end

   // present one quaternion and hold it until the transfer
   task automatic send_quat(logic [15:0] x, y, z, w);
      req_type q;
      q.qx = x; q.qy = y; q.qz = z; q.qw = w;
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      quats_sent++;
   endtask

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 4) - 2);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         2: return 16'($signed(16'($urandom_range(0, 511))) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] extremes[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001,
                                   16'hffff, 16'h4000};
      int burst;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      quats_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero quaternion, axes, unit-ish, extremes, ties
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
      send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
      send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'hffff, 16'h0001, 16'h0000, 16'h0000);
      send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0000);
      send_quat(16'h0001, 16'h0002, 16'h0003, 16'hfffc);
      for (int k = 0; k < 6; k++)
         send_quat(extremes[k], extremes[(k + 1) % 6], extremes[(k + 3) % 6],
                   extremes[(k + 5) % 6]);
      req_valid <= 1'b0;

      // drain everything once before the random part
      while (pending_matrices != 0) @(posedge clock);

      // random bursts with random gaps
      while (quats_sent < 1670) begin
         burst = $urandom_range(1, 40);
         repeat (burst)
            send_quat(random_component(), random_component(), random_component(),
                      random_component());
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending_matrices != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_matrices == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/qrm_pkg.sv
rtl/core/quaternion_to_rotation_matrix.sv
bench/qrm_checker.sv
bench/tb_top.sv
